// ===== rtl/imp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imp_pkg
// Shared constants, codes and controller/datapath signal groups of the
// in-band marker path extractor.
// ----------------------------------------------------------------------------
package imp_pkg;

	localparam int PATH_DEPTH_DEF = 32;
	localparam int MARKER_MAX_DEF = 16;

	localparam logic [7:0] PATH_END_BYTE = 8'h1E;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_MARKER_LOW    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MARKER_HIGH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MARKER_LENGTH = 2'd2;

	localparam logic [4:0] MARKER_LENGTH_RESET = 5'd14;

	localparam logic [1:0] KIND_TEXT = 2'd0;
	localparam logic [1:0] KIND_PATH = 2'd1;
	localparam logic [1:0] KIND_END  = 2'd2;

	// what an accepted byte sets off
	typedef enum logic [2:0] {
		ACT_ABSORB,
		ACT_TEXT,
		ACT_MISMATCH,
		ACT_TERM,
		ACT_OVF
	} imp_act_t;

	// source of the output byte
	typedef enum logic [2:0] {
		SRC_IN,
		SRC_MK,
		SRC_PATH,
		SRC_TERM,
		SRC_ZERO,
		SRC_CUR
	} imp_src_t;

	typedef struct packed {
		logic       in_ready;
		logic       accept;
		logic       load_out;
		imp_src_t   src;
		logic [1:0] kind;
		logic       last;
		logic       idx_clr;
		logic       idx_inc;
		logic       mem_rd;
	} imp_cmd_t;

	typedef struct packed {
		logic     in_valid;
		logic     slot_free;
		imp_act_t action;
		logic     emit_cur;
		logic     mk_done;
		logic     path_done;
		logic     path_empty;
	} imp_status_t;

	function automatic logic [7:0] marker_byte(input logic [63:0] lo, input logic [63:0] hi,
			input logic [3:0] idx);
		logic [127:0] all_b;
		all_b = {hi, lo};
		return all_b[{idx, 3'b000} +: 8];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/imp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imp_if
// Request channels of the extractor: text bytes in, result items out and
// register writes.
// ----------------------------------------------------------------------------
interface imp_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface imp_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] item_kind;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, output item_kind, output out_byte, output last, input ready);
	modport sink (input valid, input item_kind, input out_byte, input last, output ready);
endinterface

interface imp_cfg_if;
	import imp_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [63:0]          data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/imp_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imp_ctrl
// Sequencer: takes bytes, then walks marker replay, path readout, end item
// and the deferred current byte into the output register.
// ----------------------------------------------------------------------------
module imp_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  imp_pkg::imp_status_t sts,
	output imp_pkg::imp_cmd_t    cmd
);
	import imp_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MK   = 3'd1;
	localparam logic [2:0] S_PRD  = 3'd2;
	localparam logic [2:0] S_PWR  = 3'd3;
	localparam logic [2:0] S_END  = 3'd4;
	localparam logic [2:0] S_CUR  = 3'd5;

	logic [2:0] state_q, state_d;
	logic       ovf_q, ovf_d;
	logic       cur_q, cur_d;

	always_comb begin
		cmd          = '0;
		cmd.src      = SRC_IN;
		cmd.kind     = KIND_TEXT;
		state_d      = state_q;
		ovf_d        = ovf_q;
		cur_d        = cur_q;
		cmd.in_ready = (state_q == S_IDLE) && sts.slot_free;
		cmd.accept   = cmd.in_ready && sts.in_valid;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.accept) begin
					ovf_d = (sts.action == ACT_OVF);
					cur_d = sts.emit_cur;
					unique case (sts.action)
						ACT_TEXT: begin
							cmd.load_out = 1'b1;
							cmd.src      = SRC_IN;
							cmd.last     = 1'b1;
						end
						ACT_MISMATCH, ACT_OVF: begin
							cmd.idx_clr = 1'b1;
							state_d     = S_MK;
						end
						ACT_TERM: begin
							cmd.idx_clr = 1'b1;
							state_d     = sts.path_empty ? S_END : S_PRD;
						end
						default: ;
					endcase
				end
			end
			S_MK: begin
				if (sts.slot_free) begin
					cmd.load_out = 1'b1;
					cmd.src      = SRC_MK;
					cmd.last     = sts.mk_done && !ovf_q && !cur_q;
					if (sts.mk_done) begin
						cmd.idx_clr = 1'b1;
						state_d     = ovf_q ? S_PRD : (cur_q ? S_CUR : S_IDLE);
					end else begin
						cmd.idx_inc = 1'b1;
					end
				end
			end
			S_PRD: begin
				cmd.mem_rd = 1'b1;
				state_d    = S_PWR;
			end
			S_PWR: begin
				if (sts.slot_free) begin
					cmd.load_out = 1'b1;
					cmd.src      = SRC_PATH;
					cmd.kind     = ovf_q ? KIND_TEXT : KIND_PATH;
					if (sts.path_done) begin
						state_d = S_END;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = S_PRD;
					end
				end
			end
			S_END: begin
				if (sts.slot_free) begin
					cmd.load_out = 1'b1;
					// overflow spills the terminator as text
					cmd.src      = ovf_q ? SRC_TERM : SRC_ZERO;
					cmd.kind     = ovf_q ? KIND_TEXT : KIND_END;
					cmd.last     = !(ovf_q && cur_q);
					state_d      = (ovf_q && cur_q) ? S_CUR : S_IDLE;
				end
			end
			S_CUR: begin
				if (sts.slot_free) begin
					cmd.load_out = 1'b1;
					cmd.src      = SRC_CUR;
					cmd.last     = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ovf_q   <= 1'b0;
			cur_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			ovf_q   <= ovf_d;
			cur_q   <= cur_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/imp_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imp_dpath
// Marker registers, scan state, path store, replay index and the output
// register.
// ----------------------------------------------------------------------------
module imp_dpath #(
	parameter int PATH_DEPTH = imp_pkg::PATH_DEPTH_DEF,
	parameter int MARKER_MAX = imp_pkg::MARKER_MAX_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	imp_text_if.sink             text,
	imp_result_if.source         result,
	imp_cfg_if.sink              cfg,
	input  imp_pkg::imp_cmd_t    cmd,
	output imp_pkg::imp_status_t sts
);
	import imp_pkg::*;

	localparam int PW = $clog2(PATH_DEPTH);
	localparam int MW = $clog2(MARKER_MAX + 1);
	localparam int IW = (PATH_DEPTH > MARKER_MAX + 1) ? PW : MW;

	localparam logic [1:0] MODE_TEXT  = 2'd0;
	localparam logic [1:0] MODE_MATCH = 2'd1;
	localparam logic [1:0] MODE_CAP   = 2'd2;

	logic [63:0]   mk_lo_q, mk_hi_q;
	logic [4:0]    mk_length_q;
	logic [1:0]    mode_q, mode_d;
	logic [MW-1:0] matched_q, matched_d;
	logic [PW-1:0] path_cnt_q, path_cnt_d;
	logic [7:0]    path_mem [PATH_DEPTH];
	logic [7:0]    rdata_q;
	logic [IW-1:0] idx_q;
	logic [MW-1:0] mk_len_q;
	logic [PW-1:0] pth_len_q;
	logic [7:0]    cur_q;

	logic [MW-1:0] eff;
	logic [7:0]    b, mk0, mk_m, out_sel;
	logic          store, tb;
	imp_act_t      act;

	logic          out_valid_q;
	logic [1:0]    out_kind_q;
	logic [7:0]    out_byte_q;
	logic          out_last_q;

	assign b   = text.data_byte;
	assign mk0 = marker_byte(mk_lo_q, mk_hi_q, 4'd0);
	assign mk_m = marker_byte(mk_lo_q, mk_hi_q, 4'(matched_q));

	// zero acts as one, above the maximum clamps
	always_comb begin
		if (mk_length_q == 5'd0) begin
			eff = MW'(1);
		end else if (mk_length_q > 5'(MARKER_MAX)) begin
			eff = MW'(MARKER_MAX);
		end else begin
			eff = MW'(mk_length_q);
		end
	end

	always_comb begin
		act        = ACT_ABSORB;
		mode_d     = mode_q;
		matched_d  = matched_q;
		path_cnt_d = path_cnt_q;
		store      = 1'b0;
		tb         = 1'b0;
		case (mode_q)
			MODE_MATCH: begin
				if (matched_q < eff && b == mk_m) begin
					matched_d = matched_q + MW'(1);
					if (matched_d == eff) begin
						mode_d     = MODE_CAP;
						path_cnt_d = '0;
					end
				end else begin
					act = ACT_MISMATCH;
					tb  = 1'b1;
				end
			end
			MODE_CAP: begin
				if (b == PATH_END_BYTE) begin
					act        = ACT_TERM;
					mode_d     = MODE_TEXT;
					matched_d  = '0;
					path_cnt_d = '0;
				end else if (path_cnt_q != PW'(PATH_DEPTH - 1)) begin
					store      = 1'b1;
					path_cnt_d = path_cnt_q + PW'(1);
				end else begin
					act        = ACT_OVF;
					path_cnt_d = '0;
					tb         = 1'b1;
				end
			end
			default: tb = 1'b1;
		endcase
		// byte handled in text mode, possibly after a replay
		if (tb) begin
			if (b == mk0) begin
				matched_d = MW'(1);
				if (eff == MW'(1)) begin
					mode_d     = MODE_CAP;
					path_cnt_d = '0;
				end else begin
					mode_d = MODE_MATCH;
				end
			end else begin
				mode_d    = MODE_TEXT;
				matched_d = '0;
				if (act == ACT_ABSORB) act = ACT_TEXT;
			end
		end
	end

	assign sts.in_valid   = text.valid;
	assign sts.slot_free  = !out_valid_q || result.ready;
	assign sts.action     = act;
	assign sts.emit_cur   = (b != mk0);
	assign sts.mk_done    = ({1'b0, idx_q} + (IW+1)'(1)) == (IW+1)'(mk_len_q);
	assign sts.path_done  = ({1'b0, idx_q} + (IW+1)'(1)) == (IW+1)'(pth_len_q);
	assign sts.path_empty = (path_cnt_q == '0);

	assign text.ready = cmd.in_ready;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mk_lo_q     <= '0;
			mk_hi_q     <= '0;
			mk_length_q <= MARKER_LENGTH_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MARKER_LOW:    mk_lo_q     <= cfg.data;
				REG_MARKER_HIGH:   mk_hi_q     <= cfg.data;
				REG_MARKER_LENGTH: mk_length_q <= cfg.data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_TEXT;
			matched_q  <= '0;
			path_cnt_q <= '0;
			idx_q      <= '0;
		end else begin
			if (cmd.accept) begin
				mode_q     <= mode_d;
				matched_q  <= matched_d;
				path_cnt_q <= path_cnt_d;
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	// replay lengths and the held byte are latched with each request
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mk_len_q  <= (act == ACT_OVF) ? eff : matched_q;
			pth_len_q <= path_cnt_q;
			cur_q     <= b;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && store) begin
			path_mem[path_cnt_q] <= b;
		end
		if (cmd.mem_rd) begin
			rdata_q <= path_mem[idx_q[PW-1:0]];
		end
	end

	always_comb begin
		unique case (cmd.src)
			SRC_IN:   out_sel = b;
			SRC_MK:   out_sel = marker_byte(mk_lo_q, mk_hi_q, 4'(idx_q));
			SRC_PATH: out_sel = rdata_q;
			SRC_TERM: out_sel = PATH_END_BYTE;
			SRC_ZERO: out_sel = 8'd0;
			SRC_CUR:  out_sel = cur_q;
			default:  out_sel = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_kind_q <= cmd.kind;
			out_byte_q <= out_sel;
			out_last_q <= cmd.last;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.item_kind = out_kind_q;
	assign result.out_byte  = out_byte_q;
	assign result.last      = out_last_q;

endmodule
`default_nettype wire

// ===== rtl/inband_marker_path_extractor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// inband_marker_path_extractor
// Passes text bytes through, picks out paths that follow an in-band marker.
// ----------------------------------------------------------------------------
// Usage:
//   text   : one stream byte per request (valid/ready).
//   result : item_kind, out_byte, last; last marks the final item of a byte.
//   cfg    : register writes (index 0 marker bytes 0..7, 1 bytes 8..15,
//            2 marker length); always ready, write only while idle.
// Order and throughput:
//   A plain text byte is loaded into the output register on the clock edge
//   that takes its request; plain and absorbed bytes go at one per cycle
//   while the output register is free. A marker mismatch replays the
//   matched bytes at one per cycle while the output register is free, then
//   the current byte when it goes out as text; the next byte is taken after
//   that. Path readout passes each stored byte through the store read port,
//   then the output register, and ends with the end item. On overflow the
//   marker goes out first at one per cycle while the register is free; the
//   terminator takes the end item's slot, and a text current byte is last.
// Reset: text mode, no partial match, empty path; marker registers zero and
//   length 14. The path store is not cleared.
// Stall: a full output register that is not taken holds the sequencer and
//   drops text.ready; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module inband_marker_path_extractor #(
	parameter int PATH_DEPTH = imp_pkg::PATH_DEPTH_DEF,
	parameter int MARKER_MAX = imp_pkg::MARKER_MAX_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	imp_text_if.sink     text,
	imp_result_if.source result,
	imp_cfg_if.sink      cfg
);
	import imp_pkg::*;

	imp_cmd_t    cmd;
	imp_status_t sts;

	imp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	imp_dpath #(
		.PATH_DEPTH (PATH_DEPTH),
		.MARKER_MAX (MARKER_MAX)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.result (result),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts)
	);

	// a new request is only taken when the output slot can absorb a result
	a_ready_slot: assert property (@(posedge clk) disable iff (!arst_n)
		text.ready |-> (!result.valid || result.ready))
		else $error("text ready while output register blocked");

	// bursts block further requests on the next cycle
	a_burst_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && (sts.action == ACT_MISMATCH || sts.action == ACT_OVF
			|| sts.action == ACT_TERM)) |=> !text.ready)
		else $error("request taken during a replay burst");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.item_kind == KIND_END) |-> (result.last && result.out_byte == 8'd0))
		else $error("end item without last or with nonzero byte");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.item_kind != 2'd3))
		else $error("undefined item kind");

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the in-band marker path extractor. A short scripted
// run covers reset values, odd marker lengths and a length change while a
// match is open; random phases follow, mostly well-formed marker/path/
// terminator requests mixed with broken markers and plain text. Every result
// request is checked in order against a behavioural predictor or a scripted item.
// ----------------------------------------------------------------------------
module tb_top;
	import imp_pkg::*;

	localparam int PATH_DEPTH   = PATH_DEPTH_DEF;
	localparam int MARKER_MAX   = MARKER_MAX_DEF;
	localparam int ITEM_TARGET  = 410;
	localparam int HOLD_AT      = 200;
	localparam int LONG_HOLD    = 400;
	localparam int QUIET_CYCLES = 64;
	localparam int CYCLE_LIMIT  = 3000000;
	localparam int SCRIPT_ROWS  = 26;

	typedef enum logic [1:0] {SCAN_TEXT, SCAN_MARK, SCAN_PATH} scan_t;
	typedef enum logic {ROW_BYTE, ROW_REG} row_op_t;
	// how a scripted byte is checked: by the predictor, no result, or one typed item
	typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} row_chk_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] val;
		logic       last;
	} out_item_t;

	typedef struct packed {
		row_op_t              op;
		logic [CFG_IDX_W-1:0] idx;
		logic [63:0]          wdata;
		logic [7:0]           b;
		row_chk_t             chk;
		logic [1:0]           kind;
		logic [7:0]           val;
	} row_t;

	logic clk;
	logic arst_n;

	imp_text_if   text_bus();
	imp_result_if result_bus();
	imp_cfg_if    cfg_bus();

	inband_marker_path_extractor uut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_bus),
		.result (result_bus),
		.cfg    (cfg_bus)
	);

	// predictor copy of registers and state
	logic [63:0] marker_lo;
	logic [63:0] marker_hi;
	logic [4:0]  marker_len;
	scan_t       scan;
	int          matched;
	int          path_n;
	logic [7:0]  path_mem [PATH_DEPTH];

	out_item_t step_items[$];
	out_item_t outstanding[$];

	int   err_count;
	int   items_sent;
	int   cycle_count;
	logic steady;
	logic hold_req;
	logic hold_done;
	row_t script [SCRIPT_ROWS];

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic flag_mismatch(input string msg);
		err_count++;
		if (err_count <= 50)
			$display("%0t mismatch: %s", $time, msg);
	endtask

	function automatic int marker_span();
		if (marker_len == 5'd0)
			return 1;
		if (marker_len > MARKER_MAX)
			return MARKER_MAX;
		return int'(marker_len);
	endfunction

	function automatic logic [7:0] marker_at(input int i);
		if (i < 8)
			return marker_lo[8*i +: 8];
		return marker_hi[8*(i-8) +: 8];
	endfunction

	task automatic queue_item(input logic [1:0] kind, input logic [7:0] val);
		out_item_t it;
		it.kind = kind;
		it.val  = val;
		it.last = 1'b0;
		step_items.push_back(it);
	endtask

	task automatic take_as_text(input logic [7:0] b);
		if (b == marker_at(0)) begin
			matched = 1;
			if (marker_span() == 1) begin
				scan   = SCAN_PATH;
				path_n = 0;
			end else begin
				scan = SCAN_MARK;
			end
		end else begin
			queue_item(KIND_TEXT, b);
		end
	endtask

	// results caused by one accepted byte land in step_items
	task automatic extract_byte(input logic [7:0] b);
		int span;
		int i;
		span = marker_span();
		step_items.delete();
		case (scan)
			SCAN_MARK: begin
				if (matched < span && b == marker_at(matched)) begin
					matched++;
					if (matched == span) begin
						scan   = SCAN_PATH;
						path_n = 0;
					end
				end else begin
					// replay what matched so far, from the registers as they are now
					for (i = 0; i < matched; i++)
						queue_item(KIND_TEXT, marker_at(i));
					scan    = SCAN_TEXT;
					matched = 0;
					take_as_text(b);
				end
			end
			SCAN_PATH: begin
				if (b == PATH_END_BYTE) begin
					for (i = 0; i < path_n; i++)
						queue_item(KIND_PATH, path_mem[i]);
					queue_item(KIND_END, 8'h00);
					scan    = SCAN_TEXT;
					matched = 0;
					path_n  = 0;
				end else if (path_n < PATH_DEPTH - 1) begin
					path_mem[path_n] = b;
					path_n++;
				end else begin
					// overflow: whole marker, stored path and terminator go out as text
					for (i = 0; i < span; i++)
						queue_item(KIND_TEXT, marker_at(i));
					for (i = 0; i < path_n; i++)
						queue_item(KIND_TEXT, path_mem[i]);
					queue_item(KIND_TEXT, PATH_END_BYTE);
					scan    = SCAN_TEXT;
					matched = 0;
					path_n  = 0;
					take_as_text(b);
				end
			end
			default: take_as_text(b);
		endcase
		if (step_items.size() > 0)
			step_items[step_items.size()-1].last = 1'b1;
	endtask

	function automatic int pick_gap();
		int roll;
		if (steady)
			return 0;
		roll = $urandom_range(0, 9);
		if (roll < 6)
			return 0;
		if (roll < 9)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			text_bus.valid <= 1'b0;
		end
		@(negedge clk);
		text_bus.valid     <= 1'b1;
		text_bus.data_byte <= b;
		do @(posedge clk); while (!text_bus.ready);
		extract_byte(b);
		items_sent++;
	endtask

	task automatic send_checked(input logic [7:0] b);
		send_byte(b);
		foreach (step_items[k])
			outstanding.push_back(step_items[k]);
	endtask

	// sender pauses until nothing is owed and the block has settled
	task automatic wait_idle();
		@(negedge clk);
		text_bus.valid <= 1'b0;
		while (outstanding.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= val;
		do @(posedge clk); while (!cfg_bus.ready);
		case (idx)
			REG_MARKER_LOW:    marker_lo  = val;
			REG_MARKER_HIGH:   marker_hi  = val;
			REG_MARKER_LENGTH: marker_len = val[4:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic send_sequence();
		int roll;
		int span;
		int k;
		int n;
		logic [7:0] b;
		span = marker_span();
		roll = $urandom_range(0, 19);
		if (roll < 11) begin
			for (k = 0; k < span; k++)
				send_checked(marker_at(k));
			roll = $urandom_range(0, 19);
			if (roll < 8)
				n = $urandom_range(0, 5);
			else if (roll < 15)
				n = $urandom_range(6, 30);
			else if (roll < 17)
				n = PATH_DEPTH - 1;
			else
				n = $urandom_range(PATH_DEPTH, PATH_DEPTH + 4);
			for (k = 0; k < n; k++) begin
				b = 8'($urandom_range(0, 255));
				if (b == PATH_END_BYTE)
					b = ~b;
				send_checked(b);
			end
			send_checked(PATH_END_BYTE);
		end else if (roll < 15) begin
			// broken marker
			n = $urandom_range(0, span - 1);
			for (k = 0; k < n; k++)
				send_checked(marker_at(k));
			send_checked(8'($urandom_range(0, 255)));
		end else begin
			n = $urandom_range(1, 6);
			for (k = 0; k < n; k++)
				send_checked(8'($urandom_range(0, 255)));
		end
	endtask

	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (outstanding.size() == 0) begin
				flag_mismatch($sformatf("unexpected item kind %0d byte %h last %b",
					result_bus.item_kind, result_bus.out_byte, result_bus.last));
			end else begin
				want = outstanding.pop_front();
				if (result_bus.item_kind !== want.kind)
					flag_mismatch($sformatf("item_kind %0d, want %0d",
						result_bus.item_kind, want.kind));
				if (result_bus.out_byte !== want.val)
					flag_mismatch($sformatf("out_byte %h, want %h",
						result_bus.out_byte, want.val));
				if (result_bus.last !== want.last)
					flag_mismatch($sformatf("last %b, want %b",
						result_bus.last, want.last));
			end
		end
	end

	// result side: random ready, one long hold-off on request from the sender
	initial begin : sink_side
		int run_len;
		int stall_len;
		int roll;
		@(posedge arst_n);
		forever begin
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				repeat (LONG_HOLD) begin
					@(negedge clk);
					result_bus.ready <= 1'b0;
				end
			end
			if ($urandom_range(0, 9) == 0)
				run_len = $urandom_range(50, 200);
			else
				run_len = $urandom_range(1, 12);
			roll = $urandom_range(0, 19);
			if (roll < 14)
				stall_len = $urandom_range(1, 2);
			else if (roll < 19)
				stall_len = $urandom_range(3, 6);
			else
				stall_len = $urandom_range(10, 30);
			// a pending hold-off cuts the current run or stall short
			repeat (run_len) begin
				@(negedge clk);
				result_bus.ready <= 1'b1;
				if (hold_req && !hold_done)
					break;
			end
			repeat (stall_len) begin
				if (hold_req && !hold_done)
					break;
				@(negedge clk);
				result_bus.ready <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		int roll;
		int nseq;
		int k;
		logic [4:0] next_len;
		out_item_t typed;

		arst_n             = 1'b0;
		text_bus.valid     = 1'b0;
		text_bus.data_byte = 8'h00;
		cfg_bus.valid      = 1'b0;
		cfg_bus.index      = REG_MARKER_LOW;
		cfg_bus.data       = 64'd0;
		result_bus.ready   = 1'b0;
		marker_lo          = 64'd0;
		marker_hi          = 64'd0;
		marker_len         = MARKER_LENGTH_RESET;
		scan               = SCAN_TEXT;
		matched            = 0;
		path_n             = 0;
		err_count          = 0;
		items_sent         = 0;
		cycle_count        = 0;
		steady             = 1'b0;
		hold_req           = 1'b0;
		hold_done          = 1'b0;

		script = '{
			// reset marker is fourteen zero bytes
			'{ROW_BYTE, REG_MARKER_LOW, 64'd0, 8'h41, CHK_ONE, KIND_TEXT, 8'h41},
			'{ROW_BYTE, REG_MARKER_LOW, 64'd0, 8'hFF, CHK_ONE, KIND_TEXT, 8'hFF},
			'{ROW_BYTE, REG_MARKER_LOW, 64'd0, 8'h00, CHK_NONE, KIND_TEXT, 8'h00},
			'{ROW_BYTE, REG_MARKER_LOW, 64'd0, 8'h00, CHK_NONE, KIND_TEXT, 8'h00},
			'{ROW_BYTE, REG_MARKER_LOW, 64'd0, 8'h7E, CHK_MODEL, KIND_TEXT, 8'h00},
			// zero length acts as a one-byte marker
			'{ROW_REG, REG_MARKER_LOW, 64'hF0E1D2C3B4A59687, 8'h00, CHK_MODEL, KIND_TEXT, 8'h00},
			'{ROW_REG, REG_MARKER_LENGTH, 64'd0, 8'h00, CHK_MODEL, KIND_TEXT, 8'h00},
			'{ROW_BYTE, REG_MARKER_LOW, 64'd0, 8'h87, CHK_NONE, KIND_TEXT, 8'h00},
			'{ROW_BYTE, REG_MARKER_LOW, 64'd0, 8'h1E, CHK_ONE, KIND_END, 8'h00},
			'{ROW_BYTE, REG_MARKER_LOW, 64'd0, 8'h87, CHK_NONE, KIND_TEXT, 8'h00},
			'{ROW_BYTE, REG_MARKER_LOW, 64'd0, 8'h00, CHK_NONE, KIND_TEXT, 8'h00},
			'{ROW_BYTE, REG_MARKER_LOW, 64'd0, 8'hFF, CHK_NONE, KIND_TEXT, 8'h00},
			'{ROW_BYTE, REG_MARKER_LOW, 64'd0, 8'h1E, CHK_MODEL, KIND_TEXT, 8'h00},
			// shorten the marker under an open two-byte match
			'{ROW_REG, REG_MARKER_LENGTH, 64'd3, 8'h00, CHK_MODEL, KIND_TEXT, 8'h00},
			'{ROW_BYTE, REG_MARKER_LOW, 64'd0, 8'h87, CHK_NONE, KIND_TEXT, 8'h00},
			'{ROW_BYTE, REG_MARKER_LOW, 64'd0, 8'h96, CHK_NONE, KIND_TEXT, 8'h00},
			'{ROW_REG, REG_MARKER_LENGTH, 64'd2, 8'h00, CHK_MODEL, KIND_TEXT, 8'h00},
			'{ROW_BYTE, REG_MARKER_LOW, 64'd0, 8'h55, CHK_MODEL, KIND_TEXT, 8'h00},
			// mismatch on a byte that restarts the marker
			'{ROW_BYTE, REG_MARKER_LOW, 64'd0, 8'h87, CHK_NONE, KIND_TEXT, 8'h00},
			'{ROW_BYTE, REG_MARKER_LOW, 64'd0, 8'h87, CHK_MODEL, KIND_TEXT, 8'h00},
			'{ROW_BYTE, REG_MARKER_LOW, 64'd0, 8'h96, CHK_NONE, KIND_TEXT, 8'h00},
			'{ROW_BYTE, REG_MARKER_LOW, 64'd0, 8'h1E, CHK_ONE, KIND_END, 8'h00},
			// length above the maximum clips to sixteen
			'{ROW_REG, REG_MARKER_HIGH, 64'h0123456789ABCDEF, 8'h00, CHK_MODEL, KIND_TEXT, 8'h00},
			'{ROW_REG, REG_MARKER_LENGTH, 64'd31, 8'h00, CHK_MODEL, KIND_TEXT, 8'h00},
			'{ROW_BYTE, REG_MARKER_LOW, 64'd0, 8'h87, CHK_NONE, KIND_TEXT, 8'h00},
			'{ROW_BYTE, REG_MARKER_LOW, 64'd0, 8'h1E, CHK_MODEL, KIND_TEXT, 8'h00}
		};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[r]) begin
			if (script[r].op == ROW_REG) begin
				wait_idle();
				write_reg(script[r].idx, script[r].wdata);
			end else if (script[r].chk == CHK_MODEL) begin
				send_checked(script[r].b);
			end else begin
				send_byte(script[r].b);
				if (script[r].chk == CHK_ONE) begin
					typed.kind = script[r].kind;
					typed.val  = script[r].val;
					typed.last = 1'b1;
					outstanding.push_back(typed);
				end
			end
		end

		while (items_sent < ITEM_TARGET) begin
			wait_idle();
			roll = $urandom_range(0, 9);
			case (roll)
				0:       next_len = 5'd1;
				1:       next_len = 5'd16;
				2:       next_len = 5'd0;
				3:       next_len = 5'd31;
				4:       next_len = 5'($urandom_range(17, 30));
				default: next_len = 5'($urandom_range(2, 15));
			endcase
			// a length-only write may land while a match is open
			if ($urandom_range(0, 4) != 0) begin
				write_reg(REG_MARKER_LOW, {$urandom, $urandom});
				write_reg(REG_MARKER_HIGH, {$urandom, $urandom});
			end
			write_reg(REG_MARKER_LENGTH, {59'd0, next_len});
			steady = ($urandom_range(0, 3) == 0);
			nseq   = $urandom_range(2, 8);
			for (k = 0; k < nseq && items_sent < ITEM_TARGET; k++) begin
				if (!hold_req && items_sent >= HOLD_AT)
					hold_req = 1'b1;
				send_sequence();
			end
		end

		wait_idle();
		if (err_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
